// ===== rtl/spr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spr_pkg;

    localparam int BYTE_W          = 8;
    localparam int WIN_DEPTH       = 8;
    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int TEXT_W          = 64;
    localparam int LEN_W           = 4;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_TEXT       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_TEXT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE_CASE        = 3'd4;

    localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] ASCII_CASE_OFS = 8'h20;

    typedef struct packed {
        logic [TEXT_W-1:0] pattern_text;
        logic [LEN_W-1:0]  pattern_length;
        logic [TEXT_W-1:0] replacement_text;
        logic [LEN_W-1:0]  replacement_length;
        logic              ignore_case;
    } cfg_t;

    // One burst of results caused by one input transaction
    typedef struct packed {
        logic [TEXT_W-1:0] bytes;
        logic [LEN_W-1:0]  count;
        logic              no_byte;
        logic              last;
    } burst_t;

    function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c,
                                               input logic ignore_case);
        logic [BYTE_W-1:0] r;
        r = c;
        if (ignore_case && c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
            r = c + ASCII_CASE_OFS;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/spr_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spr_cfg (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [spr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [spr_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    output spr_pkg::cfg_t                         cfg
);

    spr_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern_text       <= '0;
            cfg_reg.pattern_length     <= spr_pkg::LEN_W'(1);
            cfg_reg.replacement_text   <= '0;
            cfg_reg.replacement_length <= '0;
            cfg_reg.ignore_case        <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                spr_pkg::REG_PATTERN_TEXT: begin
                    cfg_reg.pattern_text <= cfg_wr_data[spr_pkg::TEXT_W-1:0];
                end
                spr_pkg::REG_PATTERN_LENGTH: begin
                    cfg_reg.pattern_length <= cfg_wr_data[spr_pkg::LEN_W-1:0];
                end
                spr_pkg::REG_REPLACEMENT_TEXT: begin
                    cfg_reg.replacement_text <= cfg_wr_data[spr_pkg::TEXT_W-1:0];
                end
                spr_pkg::REG_REPLACEMENT_LENGTH: begin
                    cfg_reg.replacement_length <= cfg_wr_data[spr_pkg::LEN_W-1:0];
                end
                spr_pkg::REG_IGNORE_CASE: begin
                    cfg_reg.ignore_case <= cfg_wr_data[0];
                end
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/spr_match.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spr_match (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire spr_pkg::cfg_t                 cfg,
    input  wire logic                          in_accept,
    input  wire logic [spr_pkg::BYTE_W-1:0]    in_byte,
    input  wire logic                          in_end,
    output spr_pkg::burst_t                    burst
);

    localparam int BW = spr_pkg::BYTE_W;
    localparam int LW = spr_pkg::LEN_W;

    logic [BW-1:0] win_reg  [spr_pkg::WIN_DEPTH];
    logic [BW-1:0] win_app  [spr_pkg::WIN_DEPTH];
    logic [BW-1:0] win_next [spr_pkg::WIN_DEPTH];
    logic [LW-1:0] count_reg;
    logic [LW-1:0] count_next;
    logic [LW-1:0] cnt_app;
    logic [LW-1:0] plen;
    logic [LW-1:0] rlen;
    logic          match;
    logic          do_shift;

    always_comb begin
        if (cfg.pattern_length == '0) begin
            plen = LW'(1);
        end else if (cfg.pattern_length > LW'(spr_pkg::MAX_PATTERN)) begin
            plen = LW'(spr_pkg::MAX_PATTERN);
        end else begin
            plen = cfg.pattern_length;
        end

        if (cfg.replacement_length > LW'(spr_pkg::MAX_REPLACEMENT)) begin
            rlen = LW'(spr_pkg::MAX_REPLACEMENT);
        end else begin
            rlen = cfg.replacement_length;
        end

        // append the new byte unless the window is full
        cnt_app = (count_reg < LW'(spr_pkg::WIN_DEPTH)) ? count_reg + LW'(1) : count_reg;
        for (int i = 0; i < spr_pkg::WIN_DEPTH; i++) begin
            win_app[i] = (LW'(i) == count_reg) ? in_byte : win_reg[i];
        end

        match = (cnt_app == plen);
        for (int i = 0; i < spr_pkg::WIN_DEPTH; i++) begin
            if (LW'(i) < plen &&
                spr_pkg::fold(win_app[i], cfg.ignore_case) !=
                spr_pkg::fold(cfg.pattern_text[BW*i +: BW], cfg.ignore_case)) begin
                match = 1'b0;
            end
        end

        for (int i = 0; i < spr_pkg::WIN_DEPTH; i++) begin
            burst.bytes[BW*i +: BW] = win_app[i];
        end
        burst.count   = '0;
        burst.no_byte = 1'b0;
        burst.last    = in_end;
        count_next    = cnt_app;
        do_shift      = 1'b0;

        if (match) begin
            burst.bytes = cfg.replacement_text;
            burst.count = rlen;
            count_next  = '0;
        end else if (in_end) begin
            burst.count = cnt_app;
            count_next  = '0;
        end else if (cnt_app >= plen) begin
            // pass the oldest byte through
            burst.count = LW'(1);
            do_shift    = 1'b1;
            count_next  = cnt_app - LW'(1);
        end

        if (in_end && burst.count == '0) begin
            burst.bytes   = '0;
            burst.count   = LW'(1);
            burst.no_byte = 1'b1;
        end

        for (int i = 0; i < spr_pkg::WIN_DEPTH; i++) begin
            win_next[i] = win_app[i];
        end
        if (do_shift) begin
            for (int i = 0; i < spr_pkg::WIN_DEPTH - 1; i++) begin
                win_next[i] = win_app[i+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            for (int i = 0; i < spr_pkg::WIN_DEPTH; i++) begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (in_accept) begin
            count_reg <= count_next;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= LW'(spr_pkg::WIN_DEPTH))
        else $error("window count above depth");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && in_end |=> count_reg == '0)
        else $error("window not cleared after end of string");

endmodule

`default_nettype wire

// ===== rtl/spr_out.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spr_out (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          load_valid,
    input  wire spr_pkg::burst_t               load,
    output logic                               load_ready,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [spr_pkg::BYTE_W-1:0]         m_out_byte,
    output logic                               m_no_byte,
    output logic                               m_last
);

    localparam int BW = spr_pkg::BYTE_W;
    localparam int LW = spr_pkg::LEN_W;

    logic [spr_pkg::TEXT_W-1:0] data_reg;
    logic [LW-1:0]              rem_reg;
    logic                       nob_reg;
    logic                       last_reg;

    assign m_valid    = (rem_reg != '0);
    assign load_ready = (rem_reg == '0) || (rem_reg == LW'(1) && m_ready);
    assign m_out_byte = data_reg[BW-1:0];
    assign m_no_byte  = nob_reg;
    assign m_last     = last_reg && (rem_reg == LW'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else if (load_valid) begin
            rem_reg <= load.count;
        end else if (m_valid && m_ready) begin
            rem_reg <= rem_reg - LW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load_valid) begin
            data_reg <= load.bytes;
            nob_reg  <= load.no_byte;
            last_reg <= load.last;
        end else if (m_valid && m_ready) begin
            // advance to the next byte of the burst
            data_reg <= data_reg >> BW;
        end
    end

    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg <= LW'(spr_pkg::WIN_DEPTH))
        else $error("burst count above capacity");

    a_no_byte_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_no_byte |-> m_last && m_out_byte == '0 && rem_reg == LW'(1))
        else $error("no_byte result is not a lone final result");

    a_load_count: assert property (@(posedge aclk) disable iff (!aresetn)
        load_valid |=> rem_reg == $past(load.count))
        else $error("burst count not loaded");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load_valid |-> load_ready)
        else $error("burst loaded over pending results");

endmodule

`default_nettype wire

// ===== rtl/stream_pattern_replace_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// The first result of a transaction is valid in the cycle after it is accepted.
// Throughput: one input byte per cycle while each byte yields at most one result and m_ready is high;
// a byte that yields several results (replacement or end flush) holds the input
// while the single result register drains those results one byte at a time.
// Reset (aresetn low, synchronous): window empty, no pending results,
// registers at pattern_length 1 and all others zero.
module stream_pattern_replace_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [spr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [spr_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [spr_pkg::BYTE_W-1:0]        s_in_byte,
    input  wire logic                              s_end_of_string,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [spr_pkg::BYTE_W-1:0]             m_out_byte,
    output logic                                   m_no_byte,
    output logic                                   m_last
);

    spr_pkg::cfg_t   cfg;
    spr_pkg::burst_t burst;
    logic            load_ready;
    logic            in_accept;

    assign s_ready   = load_ready;
    assign in_accept = s_valid && load_ready;

    spr_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    spr_match u_match (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_accept (in_accept),
        .in_byte   (s_in_byte),
        .in_end    (s_end_of_string),
        .burst     (burst)
    );

    spr_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (in_accept),
        .load       (burst),
        .load_ready (load_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_no_byte  (m_no_byte),
        .m_last     (m_last)
    );

endmodule

`default_nettype wire

// ===== tb/sv/spr_result_checker.sv =====
`timescale 1ns / 1ps

module spr_result_checker
    import spr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [BYTE_W-1:0]     s_in_byte,
    input  logic                  s_end_of_string,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [BYTE_W-1:0]     m_out_byte,
    input  logic                  m_no_byte,
    input  logic                  m_last,
    output int unsigned           fail_count,
    output int unsigned           results_pending
);

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              no_byte;
        logic              last;
    } out_beat_t;

    out_beat_t         replaced_q[$];
    out_beat_t         want;

    logic [TEXT_W-1:0] pat_text;
    logic [LEN_W-1:0]  pat_len;
    logic [TEXT_W-1:0] rep_text;
    logic [LEN_W-1:0]  rep_len;
    logic              fold_on;

    logic [BYTE_W-1:0] win [WIN_DEPTH];
    int                win_cnt;

    initial begin
        fail_count      = 0;
        results_pending = 0;
    end

    function automatic logic [BYTE_W-1:0] lower(input logic [BYTE_W-1:0] c);
        if (fold_on && c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 100) begin
            $display("%0t ERROR: %s", $time, msg);
        end
    endtask

    // Advance the window by one byte and queue the output bytes it releases.
    task automatic replace_byte(input logic [BYTE_W-1:0] b, input logic eos);
        int        plen;
        int        rlen;
        bit        hit;
        out_beat_t beat;
        out_beat_t beats[$];
        plen = (pat_len == 0) ? 1 : ((pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len));
        rlen = (rep_len > MAX_REPLACEMENT) ? MAX_REPLACEMENT : int'(rep_len);
        if (win_cnt < WIN_DEPTH) begin
            win[win_cnt] = b;
            win_cnt++;
        end
        // compare only when the window is exactly one pattern long
        hit = (win_cnt == plen);
        for (int i = 0; i < plen; i++) begin
            if (hit && lower(win[i]) != lower(pat_text[8*i +: 8])) begin
                hit = 0;
            end
        end
        if (hit) begin
            for (int i = 0; i < rlen; i++) begin
                beats.push_back('{rep_text[8*i +: 8], 1'b0, 1'b0});
            end
            win_cnt = 0;
        end else if (eos) begin
            for (int i = 0; i < win_cnt; i++) begin
                beats.push_back('{win[i], 1'b0, 1'b0});
            end
            win_cnt = 0;
        end else if (win_cnt >= plen) begin
            beats.push_back('{win[0], 1'b0, 1'b0});
            for (int i = 1; i < WIN_DEPTH; i++) begin
                win[i-1] = win[i];
            end
            win_cnt--;
        end
        if (eos && beats.size() == 0) begin
            beats.push_back('{8'h00, 1'b1, 1'b0});
        end
        foreach (beats[i]) begin
            beat      = beats[i];
            beat.last = eos && (i == beats.size() - 1);
            replaced_q.push_back(beat);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            pat_text = '0;
            pat_len  = 4'd1;
            rep_text = '0;
            rep_len  = '0;
            fold_on  = 1'b0;
            win_cnt  = 0;
            foreach (win[i]) begin
                win[i] = '0;
            end
            replaced_q.delete();
        end else begin
            // an output at this edge always belongs to an earlier input
            if (m_valid && m_ready) begin
                if (replaced_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected output: byte %02h no_byte %0b last %0b",
                                              m_out_byte, m_no_byte, m_last));
                end else begin
                    want = replaced_q.pop_front();
                    if (m_no_byte !== want.no_byte || m_last !== want.last ||
                        m_out_byte !== want.data) begin
                        report_mismatch($sformatf(
                            "output byte %02h no_byte %0b last %0b, want %02h %0b %0b",
                            m_out_byte, m_no_byte, m_last, want.data, want.no_byte, want.last));
                    end
                end
            end
            if (s_valid && s_ready) begin
                replace_byte(s_in_byte, s_end_of_string);
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_PATTERN_TEXT:       pat_text = cfg_wr_data;
                    REG_PATTERN_LENGTH:     pat_len  = cfg_wr_data[LEN_W-1:0];
                    REG_REPLACEMENT_TEXT:   rep_text = cfg_wr_data;
                    REG_REPLACEMENT_LENGTH: rep_len  = cfg_wr_data[LEN_W-1:0];
                    REG_IGNORE_CASE:        fold_on  = cfg_wr_data[0];
                    default: ;
                endcase
            end
        end
        results_pending = replaced_q.size();
    end

endmodule

// ===== tb/sv/stream_pattern_replace_core_tb.sv =====
`timescale 1ns / 1ps

module stream_pattern_replace_core_tb;
    import spr_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_in_byte;
    logic                  s_end_of_string;
    logic                  m_valid;
    logic                  m_ready;
    logic [BYTE_W-1:0]     m_out_byte;
    logic                  m_no_byte;
    logic                  m_last;

    int unsigned           fail_count;
    int unsigned           results_pending;

    int                    send_idle_pct;
    int                    recv_idle_pct;
    int                    hold_requests;

    // stimulus-side copy of the pattern, used to shape strings that match
    logic [TEXT_W-1:0]     cur_pat;
    int                    cur_len;
    logic                  cur_nocase;

    stream_pattern_replace_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_end_of_string (s_end_of_string),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_no_byte       (m_no_byte),
        .m_last          (m_last)
    );

    spr_result_checker chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_end_of_string (s_end_of_string),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_no_byte       (m_no_byte),
        .m_last          (m_last),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: random backpressure, plus long hold-offs on request.
    initial begin
        int holds_done;
        holds_done = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_requests != holds_done) begin
                holds_done++;
                m_ready = 1'b0;
                repeat (80) @(negedge aclk);
            end
            m_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        #5_000_000;
        $display("stream_pattern_replace_core test failed");
        $finish;
    end

    task automatic wait_idle();
        while (results_pending != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en   = 1'b1;
        cfg_index   = idx;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    task automatic set_config(input logic [TEXT_W-1:0] pat, input logic [LEN_W-1:0] plen,
                              input logic [TEXT_W-1:0] rep, input logic [LEN_W-1:0] rlen,
                              input logic nocase);
        wait_idle();
        write_reg(REG_PATTERN_TEXT, pat);
        write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(plen));
        write_reg(REG_REPLACEMENT_TEXT, rep);
        write_reg(REG_REPLACEMENT_LENGTH, CFG_DATA_W'(rlen));
        write_reg(REG_IGNORE_CASE, CFG_DATA_W'(nocase));
        cur_pat    = pat;
        cur_len    = (plen == 0) ? 1 : ((plen > MAX_PATTERN) ? MAX_PATTERN : int'(plen));
        cur_nocase = nocase;
    endtask

    // Offer one transaction and hold it until accepted; called at a falling edge.
    task automatic send_item(input logic [BYTE_W-1:0] b, input logic eos);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid         = 1'b1;
        s_in_byte       = b;
        s_end_of_string = eos;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    function automatic logic [BYTE_W-1:0] flip_case(input logic [BYTE_W-1:0] b);
        if (cur_nocase && ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) &&
            $urandom_range(1) == 1) begin
            return b ^ 8'h20;
        end
        return b;
    endfunction

    function automatic logic [TEXT_W-1:0] letter_text();
        logic [TEXT_W-1:0] t;
        for (int i = 0; i < 8; i++) begin
            t[8*i +: 8] = 8'h41 + 8'($urandom_range(25)) + ($urandom_range(1) ? 8'h20 : 8'h00);
        end
        return t;
    endfunction

    // Build and send a string that, when shaped, mostly carries whole or partial pattern copies.
    task automatic send_text(input int n, input bit shaped, input bit finish, inout int sent);
        logic [BYTE_W-1:0] text[$];
        int                k;
        while (text.size() < n) begin
            if (shaped && $urandom_range(99) < 45) begin
                k = ($urandom_range(99) < 25) ? int'($urandom_range(1, cur_len)) : cur_len;
                for (int i = 0; i < k; i++) begin
                    text.push_back(flip_case(cur_pat[8*i +: 8]));
                end
            end else if (shaped && $urandom_range(1) == 1) begin
                text.push_back(flip_case(cur_pat[8*$urandom_range(cur_len - 1) +: 8]));
            end else begin
                text.push_back(8'($urandom_range(255)));
            end
        end
        foreach (text[i]) begin
            send_item(text[i], finish && (i == text.size() - 1));
        end
        sent += text.size();
    endtask

    initial begin
        int  sent;
        bit  held;
        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = '0;
        cfg_wr_data     = '0;
        s_valid         = 1'b0;
        s_in_byte       = '0;
        s_end_of_string = 1'b0;
        send_idle_pct   = 34;
        recv_idle_pct   = 69;
        hold_requests   = 0;
        cur_pat         = '0;
        cur_len         = 1;
        cur_nocase      = 1'b0;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset pattern is a single zero byte with empty replacement: zero byte is deleted
        send_item(8'h41, 1'b0);
        send_item(8'h00, 1'b1);

        set_config(64'h6261, 4'd2, 64'h5A5958, 4'd3, 1'b1);
        send_item(8'h41, 1'b0);
        send_item(8'h42, 1'b0);
        send_item(8'h63, 1'b1);
        send_item(8'h61, 1'b1);
        send_item(8'h78, 1'b0);
        send_item(8'h61, 1'b0);
        send_item(8'h62, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'h01, 1'b1);

        // deleting match on the final byte leaves an empty end
        set_config(64'h6261, 4'd2, 64'h0, 4'd0, 1'b0);
        send_item(8'h61, 1'b0);
        send_item(8'h62, 1'b1);
        send_item(8'h41, 1'b0);
        send_item(8'h62, 1'b1);

        // shorten the pattern mid-string so the window outgrows it
        set_config(64'h64636261, 4'd4, 64'h21, 4'd1, 1'b0);
        send_item(8'h78, 1'b0);
        send_item(8'h79, 1'b0);
        send_item(8'h7A, 1'b0);
        set_config(64'h64636261, 4'd1, 64'h21, 4'd1, 1'b0);
        send_item(8'h71, 1'b0);
        send_item(8'h72, 1'b1);

        for (int p = 0; p < 6; p++) begin
            case (p / 2)
                0: begin send_idle_pct = 34; recv_idle_pct = 69; end
                1: begin send_idle_pct = 69; recv_idle_pct = 34; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            case (p)
                0: set_config(letter_text(), 4'd1, {$urandom, $urandom}, 4'd0, 1'b1);
                1: set_config(letter_text(), 4'd8, {$urandom, $urandom}, 4'd8, 1'b0);
                2: set_config(letter_text(), 4'd0, {$urandom, $urandom}, 4'd15, 1'b0);
                3: set_config(letter_text(), 4'd15, {$urandom, $urandom}, 4'd1, 1'b1);
                4: set_config({TEXT_W{1'b1}}, 4'd2, 64'h0, 4'd4, 1'b0);
                default: set_config(letter_text(), 4'($urandom_range(1, 8)), {$urandom, $urandom},
                                    4'($urandom_range(0, 8)), 1'($urandom_range(1)));
            endcase
            sent = 0;
            held = 0;
            while (sent < 30) begin
                if (p == 5 && sent >= 6 && !held) begin
                    hold_requests++;
                    held = 1;
                end
                // leave some strings open across a register change
                send_text($urandom_range(1, 12), $urandom_range(99) < 80,
                          (sent + 12 < 30) || $urandom_range(1) == 1, sent);
            end
        end

        wait_idle();
        repeat (10) @(negedge aclk);
        if (fail_count == 0 && results_pending == 0) begin
            $display("stream_pattern_replace_core test passed");
        end else begin
            $display("stream_pattern_replace_core test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/spr_pkg.sv
rtl/spr_cfg.sv
rtl/spr_match.sv
rtl/spr_out.sv
rtl/stream_pattern_replace_core.sv
tb/sv/spr_result_checker.sv
tb/sv/stream_pattern_replace_core_tb.sv
